@@ hdl/lea_pkg.sv @@
// Shared types, constants and helpers for the LEA-128 cipher core.
`timescale 1ns / 1ps
package lea_pkg;

    localparam int LEA_ROUNDS = 24;
    localparam int LEA_IDX_W  = (LEA_ROUNDS > 1) ? $clog2(LEA_ROUNDS) : 1;
    localparam int LEA_AW     = 4;

    typedef logic [3:0][31:0]      t_quad;
    typedef logic [LEA_IDX_W-1:0]  t_idx;

    localparam t_quad LEA_DELTA = {32'h78df30ec, 32'h79e27c8a, 32'h44626b02, 32'hc3efe9db};
    localparam t_idx  LEA_LAST  = t_idx'(LEA_ROUNDS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXPAND,
        S_LOAD,
        S_ROUND,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load_blk;
        logic load_key;
        logic exp_step;
        logic rnd_step;
        logic decrypt;
        logic out_load;
        t_idx ram_waddr;
        t_idx ram_raddr;
    } t_dp_cmd;

    function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

@@ hdl/lea_if.sv @@
// Valid/ready channel interfaces for input blocks and result blocks.
`timescale 1ns / 1ps
interface lea_blk_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] block_word0;
    logic [31:0] block_word1;
    logic [31:0] block_word2;
    logic [31:0] block_word3;

    modport source (output valid, mode, block_word0, block_word1, block_word2, block_word3,
                    input ready);
    modport sink (input valid, mode, block_word0, block_word1, block_word2, block_word3,
                  output ready);
endinterface

interface lea_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_word0;
    logic [31:0] result_word1;
    logic [31:0] result_word2;
    logic [31:0] result_word3;

    modport source (output valid, result_word0, result_word1, result_word2, result_word3,
                    input ready);
    modport sink (input valid, result_word0, result_word1, result_word2, result_word3,
                  output ready);
endinterface

@@ hdl/lea128_block_cipher_core.sv @@
// LEA-128 block cipher core: APB key registers, controller and datapath.
// One item is a four-word block with a mode bit (0 encrypt, 1 decrypt) and gives one
// four-word result. The round unit does one of the 24 rounds per cycle, reading its round
// key from a 24-row RAM with registered read, so an item passes from acceptance through a
// load state for the first round key read, 24 round steps and a finish state that moves the
// result into the output register once it is free; the next item is accepted only after that.
// After reset or any key register write, the next item first expands the key, one round key
// per cycle. A finished result waits in the output register while the next item is accepted.
// Key registers sit at byte addresses 0, 4, 8, 12; write them only while no item is in work.
`timescale 1ns / 1ps
module lea128_block_cipher_core import lea_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [LEA_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    lea_blk_if.sink           i_blk,
    lea_res_if.source         o_res
);

    t_quad   r_key;
    t_dp_cmd cmd;
    t_quad   blk;
    t_quad   res;
    logic    key_wr;

    assign pready = 1'b1;
    assign key_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (key_wr) begin
            r_key[paddr[LEA_AW-1:2]] <= pwdata;
        end
    end

    assign prdata = r_key[paddr[LEA_AW-1:2]];

    assign blk = {i_blk.block_word3, i_blk.block_word2, i_blk.block_word1, i_blk.block_word0};

    lea_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_blk.valid),
        .i_mode      (i_blk.mode),
        .i_out_ready (o_res.ready),
        .i_key_wr    (key_wr),
        .o_in_ready  (i_blk.ready),
        .o_out_valid (o_res.valid),
        .o_cmd       (cmd)
    );

    lea_dp u_dp (
        .i_clk (i_clk),
        .i_cmd (cmd),
        .i_key (r_key),
        .i_blk (blk),
        .o_res (res)
    );

    assign o_res.result_word0 = res[0];
    assign o_res.result_word1 = res[1];
    assign o_res.result_word2 = res[2];
    assign o_res.result_word3 = res[3];

endmodule

@@ hdl/lea_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lea_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/lea_dp.sv @@
// LEA datapath: key schedule step, round function, round key RAM, result register.
`timescale 1ns / 1ps
module lea_dp import lea_pkg::*; (
    input  logic    i_clk,
    input  t_dp_cmd i_cmd,
    input  t_quad   i_key,
    input  t_quad   i_blk,
    output t_quad   o_res
);

    t_quad r_x, n_x;
    t_quad r_t, n_t;
    t_quad r_d, n_d;
    t_quad r_res;
    t_quad rk;
    t_quad kt;
    t_quad y;

    lea_ram #(
        .WIDTH (128),
        .DEPTH (LEA_ROUNDS)
    ) u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exp_step),
        .i_waddr (i_cmd.ram_waddr),
        .i_wdata (kt),
        .i_raddr (i_cmd.ram_raddr),
        .o_rdata (rk)
    );

    // key schedule: r_d[0] is the delta of this step, already rotated by the step index
    always_comb begin
        kt[0] = rol32(r_t[0] + r_d[0], 1);
        kt[1] = rol32(r_t[1] + rol32(r_d[0], 1), 3);
        kt[2] = rol32(r_t[2] + rol32(r_d[0], 2), 6);
        kt[3] = rol32(r_t[3] + rol32(r_d[0], 3), 11);
        n_d[0] = rol32(r_d[1], 1);
        n_d[1] = rol32(r_d[2], 1);
        n_d[2] = rol32(r_d[3], 1);
        n_d[3] = rol32(r_d[0], 1);
        n_t = kt;
        if (i_cmd.load_key) begin
            n_t = i_key;
            n_d = LEA_DELTA;
        end else if (!i_cmd.exp_step) begin
            n_t = r_t;
            n_d = r_d;
        end
    end

    // one round, forward or inverse
    always_comb begin
        if (!i_cmd.decrypt) begin
            y[0] = rol32((r_x[0] ^ rk[0]) + (r_x[1] ^ rk[1]), 9);
            y[1] = ror32((r_x[1] ^ rk[2]) + (r_x[2] ^ rk[1]), 5);
            y[2] = ror32((r_x[2] ^ rk[3]) + (r_x[3] ^ rk[1]), 3);
            y[3] = r_x[0];
        end else begin
            y[0] = r_x[3];
            y[1] = (ror32(r_x[0], 9) - (y[0] ^ rk[0])) ^ rk[1];
            y[2] = (rol32(r_x[1], 5) - (y[1] ^ rk[2])) ^ rk[1];
            y[3] = (rol32(r_x[2], 3) - (y[2] ^ rk[3])) ^ rk[1];
        end
        n_x = r_x;
        if (i_cmd.load_blk) begin
            n_x = i_blk;
        end else if (i_cmd.rnd_step) begin
            n_x = y;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_t <= n_t;
        r_d <= n_d;
        if (i_cmd.out_load) begin
            r_res <= r_x;
        end
    end

    assign o_res = r_res;

endmodule

@@ hdl/lea_ctrl.sv @@
// LEA controller: sequences key expansion, rounds and the result handoff.
`timescale 1ns / 1ps
module lea_ctrl import lea_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_mode,
    input  logic    i_out_ready,
    input  logic    i_key_wr,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    t_idx   r_cnt, n_cnt;
    logic   r_dec, n_dec;
    logic   r_keys_ready, n_keys_ready;
    logic   r_out_valid, n_out_valid;
    t_idx   rd_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_dec        <= 1'b0;
            r_keys_ready <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_dec        <= n_dec;
            r_keys_ready <= n_keys_ready;
            r_out_valid  <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_dec        = r_dec;
        n_keys_ready = r_keys_ready;
        o_cmd        = '0;
        o_in_ready   = (r_state == S_IDLE);

        // read address runs one round ahead of the round unit
        rd_idx = (r_state == S_ROUND && r_cnt != LEA_LAST) ? r_cnt + t_idx'(1) : '0;
        o_cmd.ram_raddr = r_dec ? LEA_LAST - rd_idx : rd_idx;
        o_cmd.ram_waddr = r_cnt;
        o_cmd.decrypt   = r_dec;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_blk = 1'b1;
                    n_dec = i_mode;
                    n_cnt = '0;
                    if (r_keys_ready) begin
                        n_state = S_LOAD;
                    end else begin
                        o_cmd.load_key = 1'b1;
                        n_state = S_EXPAND;
                    end
                end
            end
            S_EXPAND: begin
                o_cmd.exp_step = 1'b1;
                if (r_cnt == LEA_LAST) begin
                    n_cnt = '0;
                    n_keys_ready = 1'b1;
                    n_state = S_LOAD;
                end else begin
                    n_cnt = r_cnt + t_idx'(1);
                end
            end
            S_LOAD: begin
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.rnd_step = 1'b1;
                if (r_cnt == LEA_LAST) begin
                    n_cnt = '0;
                    n_state = S_FINISH;
                end else begin
                    n_cnt = r_cnt + t_idx'(1);
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_key_wr) begin
            n_keys_ready = 1'b0;
        end
        n_out_valid = o_cmd.out_load | (r_out_valid & ~i_out_ready);
    end

    assign o_out_valid = r_out_valid;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> (r_state == S_EXPAND || r_state == S_LOAD))
        else $error("accepted item did not start expansion or load");

    a_load_to_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOAD |=> (r_state == S_ROUND && r_cnt == '0))
        else $error("round sequence did not start at the first round");

    a_keys_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXPAND && r_cnt == LEA_LAST && !i_key_wr) |=> r_keys_ready)
        else $error("key expansion ended without marking keys ready");

    a_rounds_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_cnt == LEA_LAST) |=> r_state == S_FINISH)
        else $error("last round not followed by finish");

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the LEA-128 cipher core: APB key setup, blocks in, results out.
`timescale 1ns / 1ps
module tb import lea_pkg::*; ();

    typedef enum logic {
        MODE_ENC = 1'b0,
        MODE_DEC = 1'b1
    } t_blk_mode;

    typedef enum logic [1:0] {
        KEY_W0,
        KEY_W1,
        KEY_W2,
        KEY_W3
    } t_key_reg;

    class lea_cipher_tracker;
        logic [31:0] key_words [4];
        t_quad       round_keys [LEA_ROUNDS];
        bit          schedule_ok;
        t_quad       expected_blocks [$];
        t_quad       last_result;
        t_blk_mode   last_mode;
        int unsigned enc_count;
        int unsigned dec_count;
        int unsigned checked;
        int unsigned key_settings;
        int unsigned failures;

        function new();
            foreach (key_words[i]) key_words[i] = '0;
            schedule_ok  = 1'b0;
            last_result  = '0;
            last_mode    = MODE_ENC;
            enc_count    = 0;
            dec_count    = 0;
            checked      = 0;
            key_settings = 1;
            failures     = 0;
        endfunction

        static function logic [31:0] rotl(logic [31:0] v, int unsigned n);
            n = n & 31;
            if (n == 0) return v;
            return (v << n) | (v >> (32 - n));
        endfunction

        static function logic [31:0] rotr(logic [31:0] v, int unsigned n);
            n = n & 31;
            if (n == 0) return v;
            return (v >> n) | (v << (32 - n));
        endfunction

        function void write_key(t_key_reg idx, logic [31:0] v);
            key_words[idx] = v;
            schedule_ok    = 1'b0;
        endfunction

        function void expand_schedule();
            t_quad       t;
            logic [31:0] d;
            for (int i = 0; i < 4; i++) t[i] = key_words[i];
            for (int r = 0; r < LEA_ROUNDS; r++) begin
                d    = LEA_DELTA[r % 4];
                t[0] = rotl(t[0] + rotl(d, r), 1);
                t[1] = rotl(t[1] + rotl(d, r + 1), 3);
                t[2] = rotl(t[2] + rotl(d, r + 2), 6);
                t[3] = rotl(t[3] + rotl(d, r + 3), 11);
                round_keys[r] = t;
            end
            schedule_ok = 1'b1;
        endfunction

        // Accepted input block: work out its result and queue it.
        function void note_block(t_blk_mode m, t_quad blk);
            t_quad x;
            t_quad y;
            t_quad k;
            int    r;
            x = blk;
            if (!schedule_ok) expand_schedule();
            for (int i = 0; i < LEA_ROUNDS; i++) begin
                r = (m == MODE_DEC) ? (LEA_ROUNDS - 1 - i) : i;
                k = round_keys[r];
                if (m == MODE_ENC) begin
                    y[0] = rotl((x[0] ^ k[0]) + (x[1] ^ k[1]), 9);
                    y[1] = rotr((x[1] ^ k[2]) + (x[2] ^ k[1]), 5);
                    y[2] = rotr((x[2] ^ k[3]) + (x[3] ^ k[1]), 3);
                    y[3] = x[0];
                end else begin
                    y[0] = x[3];
                    y[1] = (rotr(x[0], 9) - (y[0] ^ k[0])) ^ k[1];
                    y[2] = (rotl(x[1], 5) - (y[1] ^ k[2])) ^ k[1];
                    y[3] = (rotl(x[2], 3) - (y[2] ^ k[3])) ^ k[1];
                end
                x = y;
            end
            expected_blocks.push_back(x);
            last_result = x;
            last_mode   = m;
            if (m == MODE_ENC) enc_count++;
            else dec_count++;
        endfunction

        function void check_result(t_quad got);
            t_quad want;
            if (expected_blocks.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                failures++;
                return;
            end
            want = expected_blocks.pop_front();
            checked++;
            for (int i = 0; i < 4; i++) begin
                if (got[i] !== want[i]) begin
                    $display("%0t: result_word%0d expected %08h actual %08h",
                             $time, i, want[i], got[i]);
                    failures++;
                end
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [LEA_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    lea_blk_if blk ();
    lea_res_if res ();

    lea128_block_cipher_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_blk   (blk),
        .o_res   (res)
    );

    lea_cipher_tracker board = new();
    bit steady      = 1'b0;
    int hold_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            res.ready   <= 1'b0;
        end else begin
            res.ready <= steady || ($urandom_range(99) >= 9);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready)
            board.check_result({res.result_word3, res.result_word2,
                                res.result_word1, res.result_word0});
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 32'h1 << $urandom_range(31);
            3: return ~(32'h1 << $urandom_range(31));
            default: return $urandom;
        endcase
    endfunction

    // Starts and ends at a falling edge; valid stays high for a following item.
    task automatic push_block(t_blk_mode m, t_quad w);
        while (!steady && $urandom_range(99) < 9) begin
            blk.valid <= 1'b0;
            @(negedge i_clk);
        end
        blk.valid       <= 1'b1;
        blk.mode        <= m;
        blk.block_word0 <= w[0];
        blk.block_word1 <= w[1];
        blk.block_word2 <= w[2];
        blk.block_word3 <= w[3];
        do @(posedge i_clk); while (!blk.ready);
        board.note_block(m, w);
        @(negedge i_clk);
    endtask

    task automatic close_burst();
        blk.valid <= 1'b0;
        while (board.expected_blocks.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic reg_write(t_key_reg idx, logic [31:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= LEA_AW'({idx, 2'b00});
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.write_key(idx, v);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_readback(t_key_reg idx);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= LEA_AW'({idx, 2'b00});
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== board.key_words[idx]) begin
            $display("%0t: key_word%0d readback expected %08h actual %08h",
                     $time, idx, board.key_words[idx], prdata);
            board.failures++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_key(t_quad k, logic [3:0] mask);
        for (int i = 0; i < 4; i++)
            if (mask[i]) reg_write(t_key_reg'(i), k[i]);
        for (int i = 0; i < 4; i++)
            reg_readback(t_key_reg'(i));
        board.key_settings++;
    endtask

    initial begin : stimulus
        t_quad     w;
        t_blk_mode m;
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        blk.valid       = 1'b0;
        blk.mode        = MODE_ENC;
        blk.block_word0 = '0;
        blk.block_word1 = '0;
        blk.block_word2 = '0;
        blk.block_word3 = '0;
        res.ready       = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset key, never written: first block must expand it
        push_block(MODE_ENC, '0);
        push_block(MODE_DEC, '0);
        push_block(MODE_ENC, '1);
        push_block(MODE_DEC, '1);
        close_burst();

        load_key({32'hf0e1d2c3, 32'hb4a59687, 32'h78695a4b, 32'h3c2d1e0f}, 4'hf);
        push_block(MODE_ENC, {32'h1f1e1d1c, 32'h1b1a1918, 32'h17161514, 32'h13121110});
        push_block(MODE_DEC, board.last_result);
        push_block(MODE_ENC, {32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa});
        push_block(MODE_DEC, {32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555});
        push_block(MODE_ENC, {32'h80000000, 32'h0, 32'h0, 32'h1});
        push_block(MODE_DEC, {32'h1, 32'h0, 32'h0, 32'h80000000});
        close_burst();

        load_key('1, 4'hf);
        push_block(MODE_ENC, '0);
        push_block(MODE_DEC, '1);
        push_block(MODE_DEC, board.last_result);
        close_burst();

        // one word rewritten: schedule must still be rebuilt
        load_key({32'h0, 32'h0, 32'h12345678, 32'h0}, 4'b0010);
        push_block(MODE_ENC, {32'hdeadbeef, 32'h01234567, 32'h89abcdef, 32'hfedcba98});
        push_block(MODE_DEC, board.last_result);
        close_burst();

        for (int p = 0; p < 5; p++) begin
            case (p)
                1: load_key('0, 4'hf);
                2: load_key('1, 4'hf);
                4: load_key({$urandom, $urandom, $urandom, $urandom},
                            4'b0001 << $urandom_range(3));
                default: load_key({$urandom, $urandom, $urandom, $urandom}, 4'hf);
            endcase
            steady = (p == 3);
            for (int n = 0; n < 200; n++) begin
                if (p == 2 && n == 50) hold_cycles = 400;
                if ($urandom_range(99) < 15) begin
                    m = (board.last_mode == MODE_ENC) ? MODE_DEC : MODE_ENC;
                    w = board.last_result;
                end else begin
                    m = t_blk_mode'($urandom_range(1));
                    w = {rand_word(), rand_word(), rand_word(), rand_word()};
                end
                push_block(m, w);
            end
            close_burst();
        end
        steady = 1'b0;

        repeat (60) @(negedge i_clk);
        $display("Ran %0d encrypt and %0d decrypt blocks under %0d key settings,",
                 board.enc_count, board.dec_count, board.key_settings);
        $display("with a long output stall and drains between key changes; %0d results compared.",
                 board.checked);
        if (board.failures == 0 && board.expected_blocks.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule
